[sv/tcp_keepalive_batcher_top_defines.svh]
// Assertion macros shared by the keepalive batcher RTL.
`ifndef TCP_KEEPALIVE_BATCHER_TOP_DEFINES_SVH
`define TCP_KEEPALIVE_BATCHER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define TKB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define TKB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TKB_ASSERT(lbl, prop, msg)
`define TKB_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[sv/tkb_pkg.sv]
// Types, constants and control structs of the keepalive batcher.
package tkb_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 20;
  localparam int unsigned TAG_BITS_DEF    = 16;

  localparam logic [7:0] MAX_INTERVAL = 8'd180;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [3:0] IP_V4        = 4'd4;
  localparam logic [3:0] IP_V6        = 4'd6;

  localparam logic [7:0] REG_ENABLED  = 8'd0;
  localparam logic [7:0] REG_INTERVAL = 8'd1;

  typedef enum logic [2:0] {
    CMD_OUT    = 3'd0,
    CMD_IN     = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_DFLUSH = 3'd3,
    CMD_ACK    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_PASS    = 2'd0,
    ACT_HOLD    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    NTF_NONE,
    NTF_NOW,
    NTF_TICK
  } notify_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD,
    ST_LD,
    ST_CUR
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    now_inc;
    logic    timer_dec;
    logic    hold;
    logic    wake_clear;
    logic    flush_start;
    notify_e notify;
    logic    rd_issue;
    logic    rel_load;
    logic    rel_last;
    logic    cur_load;
    action_e cur_action;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    cmd_e cmd;
    logic enabled;
    logic keepalive;
    logic full;
    logic timer_run;
    logic timer_expire;
    logic count_zero;
    logic count_one;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/tkb_if.sv]
// Handshake channel interfaces: packet/command input, result output, register writes.
interface tkb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  ip_version;
  logic [15:0] ip_length;
  logic [3:0]  ip_header_words;
  logic [7:0]  ip_protocol;
  logic [3:0]  tcp_header_words;
  logic [7:0]  tcp_flag_bits;
  logic [31:0] seq_number;
  logic [31:0] sock_next_seq;
  logic        has_socket;
  logic [15:0] packet_tag;

  modport source (
    output valid, cmd, ip_version, ip_length, ip_header_words, ip_protocol,
           tcp_header_words, tcp_flag_bits, seq_number, sock_next_seq,
           has_socket, packet_tag,
    input  ready
  );
  modport sink (
    input  valid, cmd, ip_version, ip_length, ip_header_words, ip_protocol,
           tcp_header_words, tcp_flag_bits, seq_number, sock_next_seq,
           has_socket, packet_tag,
    output ready
  );
endinterface

interface tkb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] tag;
  logic        wake_daemon;
  logic [4:0]  held_count;
  logic        last;

  modport source (output valid, action, tag, wake_daemon, held_count, last, input ready);
  modport sink (input valid, action, tag, wake_daemon, held_count, last, output ready);
endinterface

interface tkb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/tkb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tkb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 20,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tkb_dp.sv]
// Datapath: input capture, classification, queue, timers, wake flag and output register.
module tkb_dp import tkb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tkb_in_if.sink  in_i,
  tkb_cfg_if.sink cfg_i,
  tkb_out_if.source out_o,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (TAG_BITS < 16) ? TAG_BITS : 16;

  // Captured input item.
  logic [2:0]  cmd_q;
  logic [3:0]  ver_q;
  logic [15:0] len_q;
  logic [3:0]  ihw_q;
  logic [7:0]  proto_q;
  logic [3:0]  thw_q;
  logic [7:0]  flags_q;
  logic [31:0] seq_q;
  logic [31:0] nxt_q;
  logic        sock_q;
  logic [SW-1:0] tag_q;

  // Block state.
  logic          enabled_q, enabled_d;
  logic [7:0]    interval_q, interval_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   last_wake_q, last_wake_d;
  logic          wake_q, wake_d;
  logic          timer_run_q, timer_run_d;
  logic [7:0]    timer_left_q, timer_left_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_action_q;
  logic [SW-1:0] out_tag_q;
  logic          out_wake_q;
  logic [CW-1:0] out_count_q;
  logic          out_last_q;

  logic          capture;
  logic          out_free;
  logic [SW-1:0] ram_rdata;
  logic [17:0]   pay_len;
  logic          keepalive;
  logic [31:0]   wake_diff;
  logic          wake_fire;
  logic [SW+15:0] out_tag_ext;
  logic [CW+4:0]  out_count_ext;
  logic [16+SW-1:0] in_tag_ext;

  assign capture  = in_i.valid && cmd_i.in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  // Payload length: IPv4 drops both headers, IPv6 only the TCP header.
  always_comb begin
    pay_len = {2'b00, len_q} - {12'd0, thw_q, 2'b00};
    if (ver_q == IP_V4) begin
      pay_len = pay_len - {12'd0, ihw_q, 2'b00};
    end
  end

  assign keepalive = ((ver_q == IP_V4) || (ver_q == IP_V6)) && (proto_q == PROTO_TCP) &&
                     sock_q && flags_q[4] && (flags_q[2:0] == 3'b000) &&
                     (pay_len[17:1] == 17'd0) && (32'(seq_q + 32'd1) == nxt_q);

  // A tick flush judges the spacing against the incremented time.
  assign wake_diff = now_q - last_wake_q;
  always_comb begin
    case (cmd_i.notify)
      NTF_NOW:  wake_fire = wake_diff > {24'd0, interval_q};
      NTF_TICK: wake_fire = (wake_diff >= {24'd0, interval_q}) && (wake_diff != '1);
      default:  wake_fire = 1'b0;
    endcase
  end

  always_comb begin
    enabled_d    = enabled_q;
    interval_d   = interval_q;
    count_d      = count_q;
    idx_d        = idx_q;
    now_d        = now_q;
    last_wake_d  = last_wake_q;
    wake_d       = wake_q;
    timer_run_d  = timer_run_q;
    timer_left_d = timer_left_q;

    if (cmd_i.now_inc) begin
      now_d = now_q + 32'd1;
    end
    if (cmd_i.timer_dec) begin
      timer_left_d = timer_left_q - 8'd1;
    end
    if (cmd_i.wake_clear) begin
      wake_d = 1'b0;
    end
    if (cmd_i.hold) begin
      count_d = count_q + CW'(1);
      if (!timer_run_q) begin
        timer_run_d  = 1'b1;
        timer_left_d = interval_q;
      end
    end
    if (cmd_i.flush_start) begin
      idx_d        = '0;
      timer_run_d  = 1'b0;
      timer_left_d = 8'd0;
      if (wake_fire) begin
        wake_d      = 1'b1;
        last_wake_d = (cmd_i.notify == NTF_TICK) ? now_q + 32'd1 : now_q;
      end
    end
    if (cmd_i.rel_load) begin
      count_d = count_q - CW'(1);
      idx_d   = idx_q + AW'(1);
    end

    if (cfg_i.valid) begin
      if (cfg_i.index == REG_ENABLED) begin
        enabled_d = cfg_i.data[0];
        if (!cfg_i.data[0]) begin
          wake_d      = 1'b0;
          last_wake_d = 32'd0;
        end
      end else if (cfg_i.index == REG_INTERVAL) begin
        if (cfg_i.data != 8'd0) begin
          interval_d = (cfg_i.data > MAX_INTERVAL) ? MAX_INTERVAL : cfg_i.data;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.rel_load || cmd_i.cur_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      interval_q   <= MAX_INTERVAL;
      count_q      <= '0;
      idx_q        <= '0;
      now_q        <= 32'd0;
      last_wake_q  <= 32'd0;
      wake_q       <= 1'b0;
      timer_run_q  <= 1'b0;
      timer_left_q <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      enabled_q    <= enabled_d;
      interval_q   <= interval_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      now_q        <= now_d;
      last_wake_q  <= last_wake_d;
      wake_q       <= wake_d;
      timer_run_q  <= timer_run_d;
      timer_left_q <= timer_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_tag_ext = {{SW{1'b0}}, in_i.packet_tag};

  always_ff @(posedge clk_i) begin
    if (capture) begin
      cmd_q   <= in_i.cmd;
      ver_q   <= in_i.ip_version;
      len_q   <= in_i.ip_length;
      ihw_q   <= in_i.ip_header_words;
      proto_q <= in_i.ip_protocol;
      thw_q   <= in_i.tcp_header_words;
      flags_q <= in_i.tcp_flag_bits;
      seq_q   <= in_i.seq_number;
      nxt_q   <= in_i.sock_next_seq;
      sock_q  <= in_i.has_socket;
      tag_q   <= in_tag_ext[SW-1:0];
    end
    if (cmd_i.rel_load) begin
      out_action_q <= ACT_RELEASE;
      out_tag_q    <= ram_rdata;
      out_wake_q   <= wake_q;
      out_count_q  <= count_q - CW'(1);
      out_last_q   <= cmd_i.rel_last;
    end else if (cmd_i.cur_load) begin
      out_action_q <= cmd_i.cur_action;
      out_tag_q    <= tag_q;
      out_wake_q   <= wake_q;
      out_count_q  <= count_q;
      out_last_q   <= 1'b1;
    end
  end

  tkb_ram #(
    .WIDTH (SW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hold),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (tag_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_tag_ext   = {16'd0, out_tag_q};
  assign out_count_ext = {5'd0, out_count_q};

  assign out_o.valid       = out_valid_q;
  assign out_o.action      = out_action_q;
  assign out_o.tag         = out_tag_ext[15:0];
  assign out_o.wake_daemon = out_wake_q;
  assign out_o.held_count  = out_count_ext[4:0];
  assign out_o.last        = out_last_q;

  assign sts_o.in_valid     = in_i.valid;
  assign sts_o.cmd          = cmd_e'(cmd_q);
  assign sts_o.enabled      = enabled_q;
  assign sts_o.keepalive    = keepalive;
  assign sts_o.full         = count_q >= CW'(QUEUE_DEPTH);
  assign sts_o.timer_run    = timer_run_q;
  assign sts_o.timer_expire = timer_left_q <= 8'd1;
  assign sts_o.count_zero   = count_q == '0;
  assign sts_o.count_one    = count_q == CW'(1);
  assign sts_o.out_free     = out_free;

endmodule

[sv/tkb_ctrl.sv]
// Controller state machine sequencing decisions, queue walks and result transfers.
module tkb_ctrl import tkb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   pass_after_q, pass_after_d;
  logic   hold_q, hold_d;

  // Next state and the per-item flags.
  always_comb begin
    state_d      = state_q;
    pass_after_d = pass_after_q;
    hold_d       = hold_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        pass_after_d = 1'b0;
        hold_d       = 1'b0;
        state_d      = ST_IDLE;
        case (sts_i.cmd)
          CMD_OUT: begin
            if (!sts_i.enabled) begin
              state_d = ST_CUR;
            end else if (sts_i.full || !sts_i.keepalive) begin
              pass_after_d = 1'b1;
              state_d      = sts_i.count_zero ? ST_CUR : ST_RD;
            end else begin
              hold_d  = 1'b1;
              state_d = ST_CUR;
            end
          end
          CMD_IN: begin
            if (sts_i.enabled && !sts_i.count_zero) begin
              state_d = ST_RD;
            end
          end
          CMD_TICK: begin
            if (sts_i.timer_run && sts_i.timer_expire && !sts_i.count_zero) begin
              state_d = ST_RD;
            end
          end
          CMD_DFLUSH: begin
            if (!sts_i.count_zero) begin
              state_d = ST_RD;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RD: state_d = ST_LD;
      ST_LD: begin
        if (sts_i.out_free) begin
          if (sts_i.count_one) begin
            state_d = pass_after_q ? ST_CUR : ST_IDLE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_CUR: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.notify     = NTF_NONE;
    cmd_o.cur_action = ACT_PASS;
    unique case (state_q)
      ST_IDLE: cmd_o.in_ready = 1'b1;
      ST_DECIDE: begin
        case (sts_i.cmd)
          CMD_OUT: begin
            if (sts_i.enabled) begin
              if (sts_i.full || !sts_i.keepalive) begin
                cmd_o.flush_start = 1'b1;
                cmd_o.notify      = NTF_NOW;
              end else begin
                cmd_o.hold = 1'b1;
              end
            end
          end
          CMD_IN: begin
            if (sts_i.enabled) begin
              cmd_o.flush_start = 1'b1;
              cmd_o.notify      = NTF_NOW;
            end
          end
          CMD_TICK: begin
            cmd_o.now_inc = 1'b1;
            if (sts_i.timer_run) begin
              if (sts_i.timer_expire) begin
                cmd_o.flush_start = 1'b1;
                cmd_o.notify      = NTF_TICK;
              end else begin
                cmd_o.timer_dec = 1'b1;
              end
            end
          end
          CMD_DFLUSH: cmd_o.flush_start = 1'b1;
          CMD_ACK:    cmd_o.wake_clear  = 1'b1;
          default: ;
        endcase
      end
      ST_RD: cmd_o.rd_issue = 1'b1;
      ST_LD: begin
        cmd_o.rel_load = sts_i.out_free;
        cmd_o.rel_last = sts_i.count_one && !pass_after_q;
      end
      ST_CUR: begin
        cmd_o.cur_load   = sts_i.out_free;
        cmd_o.cur_action = hold_q ? ACT_HOLD : ACT_PASS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pass_after_q <= 1'b0;
      hold_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      pass_after_q <= pass_after_d;
      hold_q       <= hold_d;
    end
  end

endmodule

[sv/tcp_keepalive_batcher_top.sv]
// Top level of the TCP keepalive batcher: controller, datapath and assertions.
//
// in_i carries one command per transfer: an outgoing or incoming packet header,
// a one-second tick, a daemon flush or a daemon acknowledge. out_o carries the
// results: pass or hold for the current packet and one release per queued tag,
// the final result of each command marked by last. cfg_i writes the enabled
// and flush_interval registers and is always ready; write it only while idle.
// The decision is made in the cycle after a command's transfer, and a command
// that causes no result lets the next command transfer in the cycle after that.
// Results leave through one output register: a pass or hold is loaded into it
// from the ST_CUR state, and each released tag is first read from the queue
// RAM (registered read port) in ST_RD and then loaded into the output register
// in ST_LD; a flush releases every queued tag before any pass that follows.
// When the receiver stalls, the walk waits at the output register and the
// queue read data is held; nothing is dropped. Reset clears the counters,
// timer and wake flag, sets enabled to 0 and flush_interval to 180; the queue
// RAM needs no clearing since only entries below the held count are read.
`include "tcp_keepalive_batcher_top_defines.svh"

module tcp_keepalive_batcher_top import tkb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tkb_in_if.sink    in_i,
  tkb_cfg_if.sink   cfg_i,
  tkb_out_if.source out_o
);

  // Commands and status between the controller and the datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tkb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd)
  );

  tkb_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .out_o  (out_o),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts)
  );

  // Only one result can be loaded into the output register per cycle.
  `TKB_ASSERT_NEVER(a_one_load, dp_cmd.rel_load && dp_cmd.cur_load, "double output load")

  // A release is only loaded while the queue still holds a tag.
  `TKB_ASSERT(a_rel_nonempty, dp_cmd.rel_load |-> !dp_sts.count_zero, "release from empty queue")

  // A command transfer is always followed by a decision cycle that takes nothing.
  `TKB_ASSERT(a_one_item, (in_i.valid && in_i.ready) |=> !in_i.ready, "second item taken")

  // Loads only happen when the output register is free to take them.
  `TKB_ASSERT(a_load_free, (dp_cmd.rel_load || dp_cmd.cur_load) |-> dp_sts.out_free,
              "result overwrote a waiting result")

endmodule
